// File: design/ofa_pkg.sv
package ofa_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_TAPS_DEF  = 4;
  localparam int MAX_BLOCK_DEF = 16;

  // Fixed field and register widths.
  localparam int NUM_COEF   = 4;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int VALUE_W    = 34;
  localparam int TAP_CNT_W  = 3;
  localparam int BLK_SIZE_W = 5;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes; register i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_TAP_COUNT = 3'd0,
    REG_BLK_LEN   = 3'd1,
    REG_COEF_0    = 3'd2,
    REG_COEF_1    = 3'd3,
    REG_COEF_2    = 3'd4,
    REG_COEF_3    = 3'd5
  } reg_idx_t;

endpackage

// File: design/overlap_add_fir_filter.sv
// Channel | Direction | Handshake       | Payload
// in_*    | input     | tvalid / tready | tdata[15:0] sample, tlast final_sample
// out_*   | output    | tvalid / tready | tdata[33:0] value, tlast run_end, tuser signal_end
// cfg_*   | input     | APB, pready = 1 | tap count, block length, coef_0..coef_3 at 4*i
//
// Samples are taken one per cycle while fewer than two flushed blocks wait (two RAM banks).
// Each result passes the single multiplier of the back end in steps: one RAM read and multiply
// per tap, a drain of the pipeline, then the hand-over; each block also begins with an idle step.
// A block of len samples gives len results, plus tap_count - 1 tail sums on the final sample.
// Reset is synchronous; it clears fill count, queue, tail sums and the output valid flag.
// A stalled output holds the back end at hand-over; the front keeps filling the free bank.
module overlap_add_fir_filter #(
  parameter int MAX_TAPS  = ofa_pkg::MAX_TAPS_DEF,
  parameter int MAX_BLOCK = ofa_pkg::MAX_BLOCK_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ofa_pkg::SAMPLE_W-1:0]     in_tdata,   // [15:0] sample
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ofa_pkg::OUT_DATA_W-1:0]   out_tdata,  // [33:0] value, [39:34] zero
  output logic                             out_tlast,
  output logic                             out_tuser,  // [0] signal_end
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ofa_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ofa_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [ofa_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  localparam int FCW = $clog2(MAX_BLOCK + 1);
  localparam int TW  = $clog2(MAX_TAPS + 1);
  localparam int BAW = $clog2(MAX_BLOCK);
  localparam int DW  = FCW + TW + 2;
  localparam int CDW = ofa_pkg::CFG_DW;
  localparam int CW16 = ofa_pkg::COEF_W;

  logic [ofa_pkg::TAP_CNT_W-1:0]                     tap_count_r;
  logic [ofa_pkg::BLK_SIZE_W-1:0]                    blk_len_r;
  logic [ofa_pkg::NUM_COEF-1:0][ofa_pkg::COEF_W-1:0] coef_r;

  logic [2:0]     cfg_idx;
  logic           cfg_wr;
  logic [TW-1:0]  eff_taps;
  logic [FCW-1:0] eff_block;

  logic                         ram_we;
  logic [BAW:0]                 ram_waddr;
  logic [ofa_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [BAW:0]                 ram_raddr;
  logic [ofa_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                         job_push;
  logic [DW-1:0]                job_din;
  logic                         job_full;
  logic                         job_pop;
  logic [DW-1:0]                job_dout;
  logic                         job_empty;
  logic [ofa_pkg::VALUE_W-1:0]  res_value;

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= ofa_pkg::TAP_CNT_W'(4);
      blk_len_r   <= ofa_pkg::BLK_SIZE_W'(4);
      coef_r[0]   <= 16'sd16384;
      coef_r[1]   <= '0;
      coef_r[2]   <= '0;
      coef_r[3]   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ofa_pkg::REG_TAP_COUNT: tap_count_r <= cfg_pwdata[ofa_pkg::TAP_CNT_W-1:0];
        ofa_pkg::REG_BLK_LEN:   blk_len_r   <= cfg_pwdata[ofa_pkg::BLK_SIZE_W-1:0];
        ofa_pkg::REG_COEF_0:    coef_r[0]   <= cfg_pwdata[CW16-1:0];
        ofa_pkg::REG_COEF_1:    coef_r[1]   <= cfg_pwdata[CW16-1:0];
        ofa_pkg::REG_COEF_2:    coef_r[2]   <= cfg_pwdata[CW16-1:0];
        ofa_pkg::REG_COEF_3:    coef_r[3]   <= cfg_pwdata[CW16-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ofa_pkg::REG_TAP_COUNT: cfg_prdata = CDW'(tap_count_r);
      ofa_pkg::REG_BLK_LEN:   cfg_prdata = CDW'(blk_len_r);
      ofa_pkg::REG_COEF_0:    cfg_prdata = {{(CDW - CW16){coef_r[0][CW16-1]}}, coef_r[0]};
      ofa_pkg::REG_COEF_1:    cfg_prdata = {{(CDW - CW16){coef_r[1][CW16-1]}}, coef_r[1]};
      ofa_pkg::REG_COEF_2:    cfg_prdata = {{(CDW - CW16){coef_r[2][CW16-1]}}, coef_r[2]};
      ofa_pkg::REG_COEF_3:    cfg_prdata = {{(CDW - CW16){coef_r[3][CW16-1]}}, coef_r[3]};
      default:                cfg_prdata = '0;
    endcase
  end

  // Zero counts act as one; counts above the build limits are clamped.
  always_comb begin
    if (tap_count_r == '0) begin
      eff_taps = TW'(1);
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      eff_taps = TW'(MAX_TAPS);
    end else begin
      eff_taps = TW'(tap_count_r);
    end
    if (blk_len_r == '0) begin
      eff_block = FCW'(1);
    end else if (32'(blk_len_r) > MAX_BLOCK) begin
      eff_block = FCW'(MAX_BLOCK);
    end else begin
      eff_block = FCW'(blk_len_r);
    end
  end

  ofa_front #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (in_tvalid),
    .smp_ready (in_tready),
    .smp_data  (in_tdata),
    .smp_last  (in_tlast),
    .eff_block (eff_block),
    .eff_taps  (eff_taps),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job_desc  (job_din),
    .job_full  (job_full)
  );

  ofa_ram #(
    .WIDTH (ofa_pkg::SAMPLE_W),
    .DEPTH (2 * (1 << BAW))
  ) u_blk_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ofa_jobq #(
    .WIDTH (DW)
  ) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_din),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_dout),
    .empty (job_empty)
  );

  ofa_back #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef_r),
    .job_empty      (job_empty),
    .job_desc       (job_dout),
    .job_pop        (job_pop),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_value      (res_value),
    .res_run_end    (out_tlast),
    .res_signal_end (out_tuser)
  );

  assign out_tdata = {{(ofa_pkg::OUT_DATA_W - ofa_pkg::VALUE_W){1'b0}}, res_value};

endmodule

// File: design/ofa_ram.sv
module ofa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/ofa_jobq.sv
module ofa_jobq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign dout  = ent_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

// File: design/ofa_front.sv
module ofa_front #(
  parameter int MAX_TAPS  = ofa_pkg::MAX_TAPS_DEF,
  parameter int MAX_BLOCK = ofa_pkg::MAX_BLOCK_DEF,
  localparam int FCW = $clog2(MAX_BLOCK + 1),
  localparam int TW  = $clog2(MAX_TAPS + 1),
  localparam int BAW = $clog2(MAX_BLOCK),
  localparam int DW  = FCW + TW + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          smp_valid,
  output logic                          smp_ready,
  input  logic [ofa_pkg::SAMPLE_W-1:0]  smp_data,
  input  logic                          smp_last,
  input  logic [FCW-1:0]                eff_block,
  input  logic [TW-1:0]                 eff_taps,
  output logic                          ram_we,
  output logic [BAW:0]                  ram_waddr,
  output logic [ofa_pkg::SAMPLE_W-1:0]  ram_wdata,
  output logic                          job_push,
  output logic [DW-1:0]                 job_desc,
  input  logic                          job_full
);

  logic [FCW-1:0] fill_r;
  logic           bank_r;
  logic [FCW-1:0] fill_inc;
  logic           accept;
  logic           flush;

  // A bank is free to fill whenever fewer than two flushed blocks wait.
  assign smp_ready = !job_full;
  assign accept    = smp_valid && !job_full;
  assign fill_inc  = fill_r + FCW'(1);
  assign flush     = (fill_inc >= eff_block) || smp_last;

  assign ram_we    = accept;
  assign ram_waddr = {bank_r, fill_r[BAW-1:0]};
  assign ram_wdata = smp_data;

  // Descriptor, low bits up: block length, tap count, final flag, bank.
  assign job_push = accept && flush;
  assign job_desc = {bank_r, smp_last, eff_taps, fill_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= 1'b0;
    end else if (accept) begin
      if (flush) begin
        fill_r <= '0;
        bank_r <= ~bank_r;
      end else begin
        fill_r <= fill_inc;
      end
    end
  end

endmodule

// File: design/ofa_back.sv
module ofa_back #(
  parameter int MAX_TAPS  = ofa_pkg::MAX_TAPS_DEF,
  parameter int MAX_BLOCK = ofa_pkg::MAX_BLOCK_DEF,
  localparam int FCW = $clog2(MAX_BLOCK + 1),
  localparam int TW  = $clog2(MAX_TAPS + 1),
  localparam int BAW = $clog2(MAX_BLOCK),
  localparam int DW  = FCW + TW + 2
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic [ofa_pkg::NUM_COEF-1:0][ofa_pkg::COEF_W-1:0] coef,
  input  logic                                             job_empty,
  input  logic [DW-1:0]                                    job_desc,
  output logic                                             job_pop,
  output logic [BAW:0]                                     ram_raddr,
  input  logic [ofa_pkg::SAMPLE_W-1:0]                     ram_rdata,
  output logic                                             res_valid,
  input  logic                                             res_ready,
  output logic [ofa_pkg::VALUE_W-1:0]                      res_value,
  output logic                                             res_run_end,
  output logic                                             res_signal_end
);

  localparam int TD = MAX_TAPS - 1;
  localparam int KW = $clog2(MAX_TAPS);
  localparam int MW = $clog2(MAX_BLOCK + MAX_TAPS - 1);
  localparam int CW = MW + 1;
  localparam int VW = ofa_pkg::VALUE_W;
  localparam int PW = ofa_pkg::PROD_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]               st_r;
  logic [MW-1:0]            m_r;
  logic [KW-1:0]            k_r;
  logic                     drain_r;
  logic                     p1_vld_r;
  logic [KW-1:0]            p1_k_r;
  logic                     p2_vld_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [VW-1:0]     acc_r;
  logic signed [VW-1:0]     tail_r [TD];
  logic                     out_valid_r;
  logic [VW-1:0]            out_value_r;
  logic                     out_run_end_r;
  logic                     out_signal_end_r;

  logic [FCW-1:0]           j_len;
  logic [TW-1:0]            j_taps;
  logic                     j_fin;
  logic                     j_bank;
  logic [CW-1:0]            len_c;
  logic [CW-1:0]            ntail_c;
  logic [CW-1:0]            m_c;
  logic [CW-1:0]            k_c;
  logic [CW-1:0]            last_m;
  logic [CW-1:0]            diff;
  logic [CW-1:0]            m_next;
  logic [CW-1:0]            tail_widx;
  logic                     in_range;
  logic                     k_last;
  logic                     emit;
  logic                     out_free;
  logic                     advance;
  logic                     blk_done;
  logic                     acc_load;
  logic                     tail_store;
  logic signed [VW-1:0]     tail_sel;
  logic signed [ofa_pkg::COEF_W-1:0] csel;

  assign j_len  = job_desc[FCW-1:0];
  assign j_taps = job_desc[FCW+TW-1:FCW];
  assign j_fin  = job_desc[FCW+TW];
  assign j_bank = job_desc[FCW+TW+1];

  assign len_c   = CW'(j_len);
  assign ntail_c = CW'(j_taps) - CW'(1);
  assign m_c     = CW'(m_r);
  assign k_c     = CW'(k_r);
  assign last_m  = len_c + ntail_c - CW'(1);

  // Output m sums block[m-k]*coef[k] over the taps whose sample index lies in the block.
  assign diff      = m_c - k_c;
  assign in_range  = (k_c <= m_c) && (diff < len_c);
  assign ram_raddr = {j_bank, diff[BAW-1:0]};
  assign k_last    = (k_c == CW'(j_taps) - CW'(1));

  // Sums past the block end become the new tail unless the signal ends here.
  assign emit      = (m_c < len_c) || j_fin;
  assign out_free  = !out_valid_r || res_ready;
  assign advance   = (st_r == S_PUSH) && (!emit || out_free);
  assign blk_done  = advance && (m_c == last_m);
  assign job_pop   = blk_done;
  assign acc_load  = ((st_r == S_IDLE) && !job_empty) || (advance && (m_c != last_m));
  assign tail_store = advance && !emit;
  assign tail_widx = m_c - len_c;
  assign m_next    = (st_r == S_IDLE) ? '0 : m_c + CW'(1);

  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < TD; i++) begin
      if ((m_next == CW'(i)) && (CW'(i) < ntail_c)) begin
        tail_sel = tail_r[i];
      end
    end
  end

  always_comb begin
    csel = '0;
    for (int i = 0; i < ofa_pkg::NUM_COEF; i++) begin
      if (32'(p1_k_r) == i) begin
        csel = $signed(coef[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      m_r     <= '0;
      k_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (!job_empty) begin
            m_r  <= '0;
            k_r  <= '0;
            st_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            k_r     <= '0;
            drain_r <= 1'b0;
            st_r    <= S_DRAIN;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_DRAIN: begin
          if (drain_r) begin
            st_r <= S_PUSH;
          end else begin
            drain_r <= 1'b1;
          end
        end
        S_PUSH: begin
          if (blk_done) begin
            st_r <= S_IDLE;
          end else if (advance) begin
            m_r  <= m_r + MW'(1);
            k_r  <= '0;
            st_r <= S_ISSUE;
          end
        end
      endcase
    end
  end

  // Read, multiply and accumulate pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= (st_r == S_ISSUE) && in_range;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_k_r <= k_r;
    prod_r <= PW'($signed(ram_rdata)) * PW'(csel);
    if (acc_load) begin
      acc_r <= tail_sel;
    end else if (p2_vld_r) begin
      acc_r <= acc_r + {{(VW - PW){prod_r[PW-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TD; i++) begin
        tail_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TD; i++) begin
        if (blk_done && (j_fin || (CW'(i) >= ntail_c))) begin
          tail_r[i] <= '0;
        end else if (tail_store && (tail_widx == CW'(i))) begin
          tail_r[i] <= acc_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_value_r      <= acc_r;
      out_run_end_r    <= j_fin ? (m_c == last_m) : (m_c == len_c - CW'(1));
      out_signal_end_r <= j_fin && (m_c == last_m);
    end
  end

  assign res_valid      = out_valid_r;
  assign res_value      = out_value_r;
  assign res_run_end    = out_run_end_r;
  assign res_signal_end = out_signal_end_r;

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (!p1_vld_r && !p2_vld_r))
    else $error("multiply pipeline busy while no block is in work");

  a_job_present: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !job_empty)
    else $error("back end working without a queued block");

  a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> res_valid)
    else $error("emitted sum did not reach the output register");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (st_r == S_IDLE))
    else $error("block retired without returning to idle");

endmodule
